// File: rtl/rlbtc_pkg.sv
// Shared types and constants for the RGB LED blink and timeout controller.
// No dependencies; used by rlbtc_chan and rgb_led_blink_timeout_controller_top.
`timescale 1ns / 1ps
`default_nettype none

package rlbtc_pkg;

	// Event kinds carried on the input stream (codes 6 and 7 are unused)
	typedef enum logic [2:0] {
		MODE_TICK         = 3'd0,
		MODE_CMD          = 3'd1,
		MODE_BATT         = 3'd2,
		MODE_LINK         = 3'd3,
		MODE_PAIR_CONFIRM = 3'd4,
		MODE_PAIR_OK      = 3'd5
	} mode_e;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DEFAULT_BLINK   = 2'd0,
		REG_DEFAULT_TIMEOUT = 2'd1,
		REG_TICK            = 2'd2
	} cfg_reg_e;

	localparam int          MS_PER_SECOND       = 1000;
	localparam logic [15:0] DEF_BLINK_MS_RST    = 16'd500;
	localparam logic [25:0] DEF_TIMEOUT_MS_RST  = 26'd30000;
	localparam logic [9:0]  TICK_MS_RST         = 10'd10;

	localparam logic [23:0] COLOR_OFF   = 24'h000000;
	localparam logic [23:0] COLOR_RED   = 24'hFF0000;
	localparam logic [23:0] COLOR_GREEN = 24'h00FF00;

	// One event as presented to every channel
	typedef struct packed {
		logic        go;          // event is applied at this edge
		mode_e       mode;
		logic [1:0]  led_id;
		logic        turn_on;
		logic [23:0] rgb;
		logic        blink_en;
		logic [15:0] period;      // resolved half-period, default applied
		logic [25:0] tmo;         // resolved timeout in ms, default applied
		logic        flag;
		logic        battery_low; // value before this event
	} evt_t;

	// Configuration seen by the channels
	typedef struct packed {
		logic [15:0] default_blink;
		logic [9:0]  tick;
	} chan_cfg_t;

	// One candidate result: colour written to a channel's drive
	typedef struct packed {
		logic        vld;
		logic [23:0] rgb;
	} slot_t;

endpackage

`default_nettype wire

// File: rtl/rlbtc_chan.sv
// State and update logic of one LED channel: colour, blink, phase, period,
// elapsed count and one-shot off timer. Depends on rlbtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlbtc_chan #(
	parameter int CH_ID = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rlbtc_pkg::evt_t       evt,
	input  rlbtc_pkg::chan_cfg_t  cfg,
	output rlbtc_pkg::slot_t      slot_a,  // timeout result on a tick, else event result
	output rlbtc_pkg::slot_t      slot_b   // blink result on a tick
);
	import rlbtc_pkg::*;

	localparam logic IS_CH0 = (CH_ID == 0);
	localparam logic IS_CH2 = (CH_ID == 2);

	logic [23:0] color_q, color_d;
	logic        blink_q, blink_d;
	logic        phase_q, phase_d;
	logic [15:0] period_q, period_d;
	logic [16:0] elapsed_q, elapsed_d;
	logic        armed_q, armed_d;
	logic [25:0] left_q, left_d;
	logic [16:0] blink_sum;
	logic        cmd_hit;

	// Command addressed here and not blocked by low battery
	assign cmd_hit = ({1'b0, evt.led_id} == 3'(CH_ID)) && !(IS_CH0 && evt.battery_low);

	// Next state and results for the current event
	always_comb begin
		color_d   = color_q;
		blink_d   = blink_q;
		phase_d   = phase_q;
		period_d  = period_q;
		elapsed_d = elapsed_q;
		armed_d   = armed_q;
		left_d    = left_q;
		slot_a    = '0;
		slot_b    = '0;
		blink_sum = 17'(elapsed_q + 17'(cfg.tick));
		unique case (evt.mode)
			MODE_TICK: begin
				// off timer first
				if (armed_q && left_q != '0) begin
					if (left_q > 26'(cfg.tick)) begin
						left_d = left_q - 26'(cfg.tick);
					end else begin
						left_d = '0;
						if (!(IS_CH0 && evt.battery_low)) begin
							slot_a    = '{vld: 1'b1, rgb: COLOR_OFF};
							blink_d   = 1'b0;
							elapsed_d = '0;
							phase_d   = 1'b0;
							armed_d   = 1'b0;
						end
					end
				end
				// then blink, on the state the timer left
				blink_sum = 17'(elapsed_d + 17'(cfg.tick));
				if (blink_d && period_q != '0) begin
					if (blink_sum >= {1'b0, period_q}) begin
						elapsed_d = '0;
						phase_d   = !phase_d;
						slot_b    = '{vld: 1'b1, rgb: (phase_d ? color_q : COLOR_OFF)};
					end else begin
						elapsed_d = blink_sum;
					end
				end
			end
			MODE_CMD: begin
				if (cmd_hit) begin
					armed_d = 1'b0;
					left_d  = '0;
					if (!evt.turn_on) begin
						slot_a    = '{vld: 1'b1, rgb: COLOR_OFF};
						blink_d   = 1'b0;
						elapsed_d = '0;
						phase_d   = 1'b0;
						color_d   = COLOR_OFF;
					end else begin
						color_d   = evt.rgb;
						blink_d   = evt.blink_en;
						period_d  = evt.period;
						elapsed_d = '0;
						phase_d   = 1'b1;
						slot_a    = '{vld: 1'b1, rgb: evt.rgb};
						if (evt.tmo != '0) begin
							armed_d = 1'b1;
							left_d  = evt.tmo;
						end
					end
				end
			end
			MODE_BATT: begin
				if (IS_CH0) begin
					if (evt.flag) begin
						armed_d   = 1'b0;
						left_d    = '0;
						color_d   = COLOR_RED;
						blink_d   = 1'b1;
						period_d  = cfg.default_blink;
						elapsed_d = '0;
						phase_d   = 1'b0;
					end else begin
						blink_d = 1'b0;
						if (!armed_q) begin
							slot_a  = '{vld: 1'b1, rgb: COLOR_OFF};
							color_d = COLOR_OFF;
						end
					end
				end
			end
			MODE_LINK: begin
				if (IS_CH2) begin
					if (evt.flag) begin
						blink_d   = 1'b0;
						elapsed_d = '0;
						phase_d   = 1'b0;
						slot_a    = '{vld: 1'b1, rgb: COLOR_OFF};
					end else begin
						armed_d   = 1'b0;
						left_d    = '0;
						blink_d   = 1'b1;
						period_d  = cfg.default_blink;
						elapsed_d = '0;
						phase_d   = 1'b0;
						color_d   = COLOR_GREEN;
					end
				end
			end
			MODE_PAIR_CONFIRM: begin
				armed_d = 1'b0;
				left_d  = '0;
				blink_d = 1'b0;
				slot_a  = '{vld: 1'b1, rgb: COLOR_GREEN};
			end
			MODE_PAIR_OK: begin
				armed_d = 1'b0;
				left_d  = '0;
				blink_d = 1'b0;
				color_d = COLOR_OFF;
				slot_a  = '{vld: 1'b1, rgb: COLOR_OFF};
			end
			default: begin
			end
		endcase
	end

	// Hold channel state; advance on each applied event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q   <= IS_CH2 ? COLOR_GREEN : COLOR_OFF;
			blink_q   <= IS_CH2;
			phase_q   <= 1'b0;
			period_q  <= DEF_BLINK_MS_RST;
			elapsed_q <= '0;
			armed_q   <= 1'b0;
			left_q    <= '0;
		end else if (evt.go) begin
			color_q   <= color_d;
			blink_q   <= blink_d;
			phase_q   <= phase_d;
			period_q  <= period_d;
			elapsed_q <= elapsed_d;
			armed_q   <= armed_d;
			left_q    <= left_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/rgb_led_blink_timeout_controller_top.sv
// Top level of the RGB LED blink and timeout controller: input register,
// channel array, result bank and output serialiser. Depends on rlbtc_pkg, rlbtc_chan.
`timescale 1ns / 1ps
`default_nettype none

// Each event transfer on the input stream lands in an input register and is
// applied to all channels together once the result bank is free; the colour
// updates it causes are loaded into the bank and leave one per cycle, while
// the output stream is ready, the final one of each event with tlast set. An
// event with k results (k at most NUM_CHANNELS, as a channel whose timer fires
// stops blinking) holds the bank until the last of them is taken; one with none
// leaves it free. The next event is taken into the input register while results
// are still leaving and is applied in the cycle the last of them is taken.
// Configuration writes are always ready and take effect at once.
module rgb_led_blink_timeout_controller_top #(
	parameter int NUM_CHANNELS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	// event stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // led_id, turn_on, red_in, green_in, blue_in,
	                                   // timeout_seconds, blink_enable, blink_period_ms,
	                                   // level_flag, zero fill
	input  logic [2:0]  s_axis_tuser,  // mode
	// colour update stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // led_index, red_out, green_out, blue_out, zero fill
	output logic        m_axis_tlast,  // last_of_run
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [25:0] cfg_data
);
	import rlbtc_pkg::*;

	localparam int NRES = 2 * NUM_CHANNELS;
	localparam int SW   = $clog2(NRES);

	// configuration registers
	logic [15:0] default_blink_q;
	logic [25:0] default_timeout_q;
	logic [9:0]  tick_q;

	// input register
	logic        vld_s1;
	mode_e       mode_s1;
	logic [1:0]  led_id_s1;
	logic        turn_on_s1;
	logic [23:0] rgb_s1;
	logic        blink_en_s1;
	logic [15:0] period_s1;
	logic [25:0] tmo_s1;
	logic        flag_s1;

	logic        battery_low_q;
	logic        go;
	logic        buf_free;
	logic [15:0] in_tsec;
	logic [15:0] in_period;
	logic [25:0] tsec_ms;

	evt_t        evt;
	chan_cfg_t   ccfg;
	slot_t       slot_a [NUM_CHANNELS];
	slot_t       slot_b [NUM_CHANNELS];

	// result bank
	logic [NRES-1:0] mask_q;
	logic [NRES-1:0] new_mask;
	logic [23:0]     res_rgb_q [NRES];
	logic [SW-1:0]   sel;
	logic [2:0]      sel_ch;
	logic            out_xfer;

	// Configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_blink_q   <= DEF_BLINK_MS_RST;
			default_timeout_q <= DEF_TIMEOUT_MS_RST;
			tick_q            <= TICK_MS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEFAULT_BLINK:   default_blink_q   <= cfg_data[15:0];
				REG_DEFAULT_TIMEOUT: default_timeout_q <= cfg_data;
				REG_TICK:            tick_q            <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// Resolve defaults on the way in
	assign in_tsec   = s_axis_tdata[42:27];
	assign in_period = s_axis_tdata[59:44];
	assign tsec_ms   = 26'({10'd0, in_tsec} * 26'(MS_PER_SECOND));

	// Bank can take an event when empty or when its last result leaves now
	assign buf_free      = (mask_q == '0) || (m_axis_tready && m_axis_tlast);
	assign go            = vld_s1 && buf_free;
	assign s_axis_tready = !vld_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1     <= mode_e'(s_axis_tuser);
			led_id_s1   <= s_axis_tdata[1:0];
			turn_on_s1  <= s_axis_tdata[2];
			rgb_s1      <= {s_axis_tdata[10:3], s_axis_tdata[18:11], s_axis_tdata[26:19]};
			blink_en_s1 <= s_axis_tdata[43];
			period_s1   <= (in_period != '0) ? in_period : default_blink_q;
			tmo_s1      <= (in_tsec != '0) ? tsec_ms : default_timeout_q;
			flag_s1     <= s_axis_tdata[60];
		end
	end

	// Event seen by every channel
	always_comb begin
		evt.go          = go;
		evt.mode        = mode_s1;
		evt.led_id      = led_id_s1;
		evt.turn_on     = turn_on_s1;
		evt.rgb         = rgb_s1;
		evt.blink_en    = blink_en_s1;
		evt.period      = period_s1;
		evt.tmo         = tmo_s1;
		evt.flag        = flag_s1;
		evt.battery_low = battery_low_q;
		ccfg.default_blink = default_blink_q;
		ccfg.tick          = tick_q;
	end

	// Channel array
	for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
		rlbtc_chan #(
			.CH_ID (g)
		) u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.evt    (evt),
			.cfg    (ccfg),
			.slot_a (slot_a[g]),
			.slot_b (slot_b[g])
		);
	end

	// Battery state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			battery_low_q <= 1'b0;
		end else if (go) begin
			if (mode_s1 == MODE_BATT) begin
				battery_low_q <= flag_s1;
			end else if (mode_s1 == MODE_PAIR_OK) begin
				battery_low_q <= 1'b0;
			end
		end
	end

	// Order results: all first slots by channel, then all second slots
	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			new_mask[i]                = slot_a[i].vld;
			new_mask[NUM_CHANNELS + i] = slot_b[i].vld;
		end
	end

	// Pick the lowest pending result
	always_comb begin
		sel = '0;
		for (int i = NRES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = SW'(i);
			end
		end
		sel_ch = (int'(sel) >= NUM_CHANNELS) ? 3'(int'(sel) - NUM_CHANNELS) : 3'(sel);
	end

	assign out_xfer      = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (mask_q != '0);
	assign m_axis_tlast  = ((mask_q & (mask_q - NRES'(1))) == '0);
	assign m_axis_tdata  = {6'd0, res_rgb_q[sel][7:0], res_rgb_q[sel][15:8],
		res_rgb_q[sel][23:16], sel_ch[1:0]};

	// Load the bank on an event, drop each result as it is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (go) begin
			mask_q <= new_mask;
		end else if (out_xfer) begin
			mask_q <= mask_q & ~(NRES'(1) << sel);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				res_rgb_q[i]                <= slot_a[i].rgb;
				res_rgb_q[NUM_CHANNELS + i] <= slot_b[i].rgb;
			end
		end
	end

`ifndef ASSERT_OFF
	// An event is applied only when no earlier result would be overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> (mask_q == '0) || (m_axis_tready && m_axis_tlast))
		else $error("result bank overwritten while results pending");

	// After the final result leaves with nothing new, the stream goes idle
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && m_axis_tlast && !go) |=> !m_axis_tvalid)
		else $error("results left over after final transfer");

	// A command updates at most one channel
	a_cmd_single: assert property (@(posedge clk) disable iff (!arst_n)
		(go && mode_s1 == MODE_CMD) |-> ($countones(new_mask) <= 1))
		else $error("command produced more than one result");

	// Pair success always clears the battery-low condition
	a_pair_clears_batt: assert property (@(posedge clk) disable iff (!arst_n)
		(go && mode_s1 == MODE_PAIR_OK) |=> !battery_low_q)
		else $error("battery low survived pair success");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for rgb_led_blink_timeout_controller_top: random event streams
// against a behavioural colour-update predictor. Depends on rlbtc_pkg and the top level.
`timescale 1ns / 1ps

module tb;
	import rlbtc_pkg::*;

	localparam int NCH = 3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PER_PHASE = 58;
	localparam int NUM_PHASES = 7;
	localparam int REPORT_CAP = 40;
	// unused event codes, 6 and 7
	localparam logic [2:0] MODE_RESERVED = 3'd6;

	typedef struct {
		logic [2:0]  mode;
		logic [1:0]  led_id;
		logic        turn_on;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] tsec;
		logic        blink_en;
		logic [15:0] period;
		logic        flag;
	} led_event_t;

	typedef struct {
		logic [1:0]  ch;
		logic [23:0] rgb;
		logic        last;
	} colour_upd_t;

	// Predicts the colour updates each event causes and checks the output stream
	class led_colour_model;
		logic [15:0] def_blink;
		logic [25:0] def_timeout;
		logic [9:0]  tick_len;
		logic [23:0] colour [NCH];
		bit          blinking [NCH];
		bit          phase_on [NCH];
		logic [15:0] half_period [NCH];
		logic [16:0] elapsed [NCH];
		bit          armed [NCH];
		logic [25:0] time_left [NCH];
		bit          batt_low;
		colour_upd_t pending_colours[$];
		int          errors;

		function new();
			def_blink = DEF_BLINK_MS_RST;
			def_timeout = DEF_TIMEOUT_MS_RST;
			tick_len = TICK_MS_RST;
			for (int i = 0; i < NCH; i++) begin
				colour[i] = COLOR_OFF;
				blinking[i] = 0;
				phase_on[i] = 0;
				half_period[i] = DEF_BLINK_MS_RST;
				elapsed[i] = '0;
				armed[i] = 0;
				time_left[i] = '0;
			end
			colour[2] = COLOR_GREEN;
			blinking[2] = 1;
			batt_low = 0;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_e idx, logic [25:0] value);
			case (idx)
				REG_DEFAULT_BLINK: def_blink = value[15:0];
				REG_DEFAULT_TIMEOUT: def_timeout = value;
				REG_TICK: tick_len = value[9:0];
				default: ;
			endcase
		endfunction

		function void drive(int ch, logic [23:0] rgb);
			colour_upd_t u;
			u.ch = ch[1:0];
			u.rgb = rgb;
			u.last = 0;
			pending_colours.push_back(u);
		endfunction

		function void halt_blink(int ch);
			blinking[ch] = 0;
			elapsed[ch] = '0;
			phase_on[ch] = 0;
		endfunction

		function void apply_event(led_event_t e);
			int base;
			int id;
			logic [31:0] tmo;
			base = pending_colours.size();
			id = e.led_id;
			case (e.mode)
				MODE_TICK: begin
					// off timers first
					for (int i = 0; i < NCH; i++) begin
						if (!armed[i] || time_left[i] == 0)
							continue;
						if (time_left[i] > 26'(tick_len)) begin
							time_left[i] = time_left[i] - 26'(tick_len);
							continue;
						end
						time_left[i] = '0;
						if (i == 0 && batt_low)
							continue;
						drive(i, COLOR_OFF);
						halt_blink(i);
						armed[i] = 0;
					end
					// then blinks
					for (int i = 0; i < NCH; i++) begin
						if (!blinking[i] || half_period[i] == 0)
							continue;
						elapsed[i] = elapsed[i] + 17'(tick_len);
						if (elapsed[i] >= 17'(half_period[i])) begin
							elapsed[i] = '0;
							phase_on[i] = !phase_on[i];
							drive(i, phase_on[i] ? colour[i] : COLOR_OFF);
						end
					end
				end
				MODE_CMD: begin
					if (id < NCH && !(id == 0 && batt_low)) begin
						armed[id] = 0;
						time_left[id] = '0;
						if (!e.turn_on) begin
							drive(id, COLOR_OFF);
							halt_blink(id);
							colour[id] = COLOR_OFF;
						end else begin
							colour[id] = {e.red, e.green, e.blue};
							blinking[id] = e.blink_en;
							half_period[id] = (e.period != 0) ? e.period : def_blink;
							elapsed[id] = '0;
							phase_on[id] = 1;
							drive(id, colour[id]);
							tmo = (e.tsec != 0) ? 32'(e.tsec) * 32'(MS_PER_SECOND)
								: 32'(def_timeout);
							if (tmo != 0) begin
								armed[id] = 1;
								time_left[id] = tmo[25:0];
							end
						end
					end
				end
				MODE_BATT: begin
					batt_low = e.flag;
					if (e.flag) begin
						armed[0] = 0;
						time_left[0] = '0;
						colour[0] = COLOR_RED;
						blinking[0] = 1;
						half_period[0] = def_blink;
						elapsed[0] = '0;
						phase_on[0] = 0;
					end else begin
						blinking[0] = 0;
						if (!armed[0]) begin
							drive(0, COLOR_OFF);
							colour[0] = COLOR_OFF;
						end
					end
				end
				MODE_LINK: begin
					if (e.flag) begin
						halt_blink(2);
						drive(2, COLOR_OFF);
					end else begin
						armed[2] = 0;
						time_left[2] = '0;
						blinking[2] = 1;
						half_period[2] = def_blink;
						elapsed[2] = '0;
						phase_on[2] = 0;
						colour[2] = COLOR_GREEN;
					end
				end
				MODE_PAIR_CONFIRM, MODE_PAIR_OK: begin
					for (int i = 0; i < NCH; i++) begin
						armed[i] = 0;
						time_left[i] = '0;
						blinking[i] = 0;
						if (e.mode == MODE_PAIR_OK)
							colour[i] = COLOR_OFF;
					end
					for (int i = 0; i < NCH; i++)
						drive(i, (e.mode == MODE_PAIR_OK) ? COLOR_OFF : COLOR_GREEN);
					if (e.mode == MODE_PAIR_OK)
						batt_low = 0;
				end
				default: ;
			endcase
			// mark the final update of this event
			if (pending_colours.size() > base)
				pending_colours[pending_colours.size() - 1].last = 1;
		endfunction

		function void field_check(string name, logic [23:0] want, logic [23:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_update(logic [31:0] data, logic last);
			colour_upd_t u;
			if (pending_colours.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: unexpected colour update, expected none, actual %h last %b",
						$time, data, last);
				return;
			end
			u = pending_colours.pop_front();
			field_check("led_index", 24'(u.ch), 24'(data[1:0]));
			field_check("red", 24'(u.rgb[23:16]), 24'(data[9:2]));
			field_check("green", 24'(u.rgb[15:8]), 24'(data[17:10]));
			field_check("blue", 24'(u.rgb[7:0]), 24'(data[25:18]));
			field_check("last", 24'(u.last), 24'(last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [25:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;
	led_colour_model board;

	rgb_led_blink_timeout_controller_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result stream at random
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check every colour update transfer
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_update(m_axis_tdata, m_axis_tlast);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Present one event, holding it until the transfer, after a random idle gap
	task automatic send_event(led_event_t e);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= e.mode;
		s_axis_tdata <= {3'b000, e.flag, e.period, e.blink_en, e.tsec,
			e.blue, e.green, e.red, e.turn_on, e.led_id};
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.apply_event(e);
	endtask

	task automatic write_reg(cfg_reg_e idx, logic [25:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.set_reg(idx, value);
	endtask

	// Let the block drain before touching configuration
	task automatic wait_drained();
		while (board.pending_colours.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic led_event_t led_cmd(logic [1:0] id, logic on, logic [23:0] rgb,
		logic [15:0] tsec, logic blink, logic [15:0] period);
		led_event_t e;
		e.mode = MODE_CMD;
		e.led_id = id;
		e.turn_on = on;
		{e.red, e.green, e.blue} = rgb;
		e.tsec = tsec;
		e.blink_en = blink;
		e.period = period;
		e.flag = 1'b0;
		return e;
	endfunction

	function automatic led_event_t plain_event(logic [2:0] mode, logic flag);
		led_event_t e;
		e = led_cmd(2'd0, 1'b0, COLOR_OFF, 16'd0, 1'b0, 16'd0);
		e.mode = mode;
		e.flag = flag;
		return e;
	endfunction

	initial begin
		led_event_t e;
		int r;
		board = new();

		// Hold reset, then release it
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: field extremes, every event kind, the corner cases
		send_event(plain_event(MODE_TICK, 1'b0));
		send_event(led_cmd(2'd0, 1'b1, 24'hFFFFFF, 16'hFFFF, 1'b1, 16'hFFFF));
		send_event(led_cmd(2'd1, 1'b1, 24'h000000, 16'd0, 1'b0, 16'd0));
		send_event(led_cmd(2'd1, 1'b1, 24'h5A3CC3, 16'd0, 1'b1, 16'd5));
		send_event(plain_event(MODE_TICK, 1'b0));
		send_event(plain_event(MODE_TICK, 1'b1));
		send_event(led_cmd(2'd3, 1'b1, 24'hFFFFFF, 16'd1, 1'b1, 16'd1));
		send_event(led_cmd(2'd2, 1'b0, 24'hFFFFFF, 16'hFFFF, 1'b1, 16'hFFFF));
		send_event(led_cmd(2'd1, 1'b0, 24'h000000, 16'd0, 1'b0, 16'd0));
		send_event(plain_event(MODE_BATT, 1'b1));
		send_event(led_cmd(2'd0, 1'b1, 24'h00FFFF, 16'd3, 1'b0, 16'd0));
		send_event(plain_event(MODE_TICK, 1'b0));
		send_event(plain_event(MODE_BATT, 1'b0));
		send_event(led_cmd(2'd0, 1'b1, 24'h0000FF, 16'd2, 1'b0, 16'd0));
		send_event(plain_event(MODE_BATT, 1'b0));
		send_event(plain_event(MODE_LINK, 1'b1));
		send_event(plain_event(MODE_LINK, 1'b0));
		send_event(plain_event(MODE_TICK, 1'b0));
		send_event(plain_event(MODE_PAIR_CONFIRM, 1'b0));
		send_event(plain_event(MODE_PAIR_OK, 1'b0));
		send_event(plain_event(MODE_RESERVED, 1'b1));
		send_event(plain_event(MODE_RESERVED | 3'd1, 1'b0));
		send_event(plain_event(MODE_BATT, 1'b1));
		send_event(plain_event(MODE_PAIR_OK, 1'b1));
		send_event(led_cmd(2'd0, 1'b1, 24'hAAAAAA, 16'd1, 1'b1, 16'd1));

		// Random phases, each with its own settings and one of four idling patterns
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			s_axis_tvalid <= 1'b0;
			send_idle_pct = 0;
			recv_stall_pct = 0;
			if (ph != 0) begin
				wait_drained();
				case (ph)
					1: begin
						write_reg(REG_DEFAULT_BLINK, 26'd1);
						write_reg(REG_DEFAULT_TIMEOUT, 26'd1);
						write_reg(REG_TICK, 26'd1);
					end
					2: begin
						write_reg(REG_DEFAULT_BLINK, 26'd65535);
						write_reg(REG_DEFAULT_TIMEOUT, 26'd67108863);
						write_reg(REG_TICK, 26'd1000);
					end
					3: begin
						write_reg(REG_DEFAULT_BLINK, 26'd40);
						write_reg(REG_DEFAULT_TIMEOUT, 26'd2500);
						write_reg(REG_TICK, 26'd1000);
					end
					5: begin
						write_reg(REG_DEFAULT_BLINK, 26'd7);
						write_reg(REG_DEFAULT_TIMEOUT, 26'd300);
						write_reg(REG_TICK, 26'd3);
					end
					default: begin
						write_reg(REG_DEFAULT_BLINK, 26'($urandom_range(600, 1)));
						write_reg(REG_DEFAULT_TIMEOUT, 26'($urandom_range(5000, 1)));
						write_reg(REG_TICK, 26'($urandom_range(1000, 1)));
					end
				endcase
				cfg_valid <= 1'b0;
			end
			case (ph % 4)
				1: send_idle_pct = 72;
				2: recv_stall_pct = 72;
				3: begin
					send_idle_pct = 12;
					recv_stall_pct = 12;
				end
				default: ;
			endcase

			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// random content in every field, then shape commands
				e.led_id = 2'($urandom);
				e.turn_on = 1'($urandom);
				e.red = 8'($urandom);
				e.green = 8'($urandom);
				e.blue = 8'($urandom);
				e.tsec = 16'($urandom);
				e.blink_en = 1'($urandom);
				e.period = 16'($urandom);
				e.flag = 1'($urandom);
				r = $urandom_range(99);
				if (r < 40)
					e.mode = MODE_TICK;
				else if (r < 76)
					e.mode = MODE_CMD;
				else if (r < 83)
					e.mode = MODE_BATT;
				else if (r < 90)
					e.mode = MODE_LINK;
				else if (r < 94)
					e.mode = MODE_PAIR_CONFIRM;
				else if (r < 97)
					e.mode = MODE_PAIR_OK;
				else
					e.mode = MODE_RESERVED | 3'($urandom_range(1));
				if (e.mode == MODE_CMD) begin
					e.turn_on = ($urandom_range(99) < 80);
					r = $urandom_range(99);
					if (r < 20)
						e.tsec = '0;
					else if (r < 80)
						e.tsec = 16'($urandom_range(4, 1));
					r = $urandom_range(99);
					if (r < 30)
						e.period = '0;
					else if (r < 80)
						e.period = 16'($urandom_range(3000, 1));
				end
				send_event(e);
			end
		end
		s_axis_tvalid <= 1'b0;

		// Drain, then allow for any trailing activity
		while (board.pending_colours.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
